FILE: src/sorted_priority_task_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority task queue: assertion macros
// Shared macros for the concurrent checks on the queue's ports.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_TASK_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue package
// Result status codes and the control word broadcast to the cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Status of one result word.
   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // Command codes of a request word.
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // Control that every cell of the chain sees in the same cycle.
   typedef struct packed {
      logic enq;  // insert the new entry, shifting the tail toward the rear
      logic deq;  // shift every entry one place toward the front
   } cell_ctrl_type;

endpackage

FILE: src/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  priority_req;
   logic [63:0] task_tag;

   modport source (output valid, command, priority_req, task_tag, input ready);
   modport sink   (input valid, command, priority_req, task_tag, output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] out_tag;
   logic [7:0]  out_priority;
   logic [4:0]  occupancy;

   modport source (output valid, status, out_tag, out_priority, occupancy, input ready);
   modport sink   (input valid, status, out_tag, out_priority, occupancy, output ready);
endinterface

FILE: src/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue cell
// One queue slot: holds a priority and a tag and trades them with its
// neighbors on an insert or a removal.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PRIO_W = 8,
   parameter int TAG_W  = 64
) (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  logic                  left_ge,
   input  logic [PRIO_W-1:0]     new_prio,
   input  logic [TAG_W-1:0]      new_tag,
   input  logic [PRIO_W-1:0]     left_prio,
   input  logic [TAG_W-1:0]      left_tag,
   input  logic [PRIO_W-1:0]     right_prio,
   input  logic [TAG_W-1:0]      right_tag,
   output logic                  ge,
   output logic [PRIO_W-1:0]     prio,
   output logic [TAG_W-1:0]      tag
);

   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   // This slot stays ahead of the new entry when it holds an equal or higher
   // priority, which keeps equal priorities in arrival order.
   assign ge = occupied && (prio_ff >= new_prio);

   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (ctrl.enq) begin
         if (!ge) begin
            if (left_ge) begin
               prio_in = new_prio;
               tag_in  = new_tag;
            end else begin
               prio_in = left_prio;
               tag_in  = left_tag;
            end
         end
      end else if (ctrl.deq) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule

FILE: src/sorted_priority_task_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue
// Bounded queue of task tags kept in priority order by a chain of cells.
// ----------------------------------------------------------------------------
//
//   Channel    Direction   Word carries
//   req_chan   in          command, priority_req, task_tag
//   rsp_chan   out         status, out_tag, out_priority, occupancy
//
// Every accepted request word yields exactly one response word, registered in
// the cycle after acceptance. A new request word is taken in every cycle in
// which the response register is empty or is being drained, so the sustained
// rate is one word per cycle; the cell chain updates all slots at once.
// A stall on the response side holds the response register and stops
// intake. Reset is synchronous and empties the queue; slot contents are not
// cleared, since only occupied slots are ever read.
//
module sorted_priority_task_queue #(
   parameter int DEPTH         = 16,
   parameter int TAG_BYTES     = 8,
   parameter int PRIORITY_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int TAG_W  = TAG_BYTES * 8;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Occupancy and response registers.
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff;
   spq_pkg::status_type  status_ff, status_in;
   logic [63:0]          out_tag_ff, out_tag_in;
   logic [7:0]           out_prio_ff, out_prio_in;

   logic                 req_fire;
   logic                 full;
   logic                 empty;
   spq_pkg::cell_ctrl_type ctrl;

   logic [PRIORITY_BITS-1:0] new_prio;
   logic [TAG_W-1:0]         new_tag;

   logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
   logic [TAG_W-1:0]         cell_tag  [DEPTH];
   logic [DEPTH-1:0]         cell_ge;

   // Intake is open whenever the response register is free or drains now.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Fields are kept at the configured widths; unused high bits drop here.
   assign new_prio = PRIORITY_BITS'(req_chan.priority_req);
   assign new_tag  = TAG_W'(req_chan.task_tag);

   // The chain only moves on an accepted word that changes the queue.
   assign ctrl.enq = req_fire && (req_chan.command == spq_pkg::CMD_ENQUEUE) && !full;
   assign ctrl.deq = req_fire && (req_chan.command == spq_pkg::CMD_DEQUEUE) && !empty;

   // The chain of slots. Slot zero is the front of the queue. On an insert
   // the first slot that is not ahead of the new entry takes it, and every
   // slot behind takes its left neighbor. On a removal every slot takes its
   // right neighbor; the last slot keeps its stale value, which then lies
   // beyond the occupancy.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

      logic                     left_ge;
      logic [PRIORITY_BITS-1:0] left_prio;
      logic [TAG_W-1:0]         left_tag;
      logic [PRIORITY_BITS-1:0] right_prio;
      logic [TAG_W-1:0]         right_tag;

      if (i == 0) begin : g_front
         assign left_ge   = 1'b1;
         assign left_prio = new_prio;
         assign left_tag  = new_tag;
      end else begin : g_inner_left
         assign left_ge   = cell_ge[i-1];
         assign left_prio = cell_prio[i-1];
         assign left_tag  = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_rear
         assign right_prio = cell_prio[i];
         assign right_tag  = cell_tag[i];
      end else begin : g_inner_right
         assign right_prio = cell_prio[i+1];
         assign right_tag  = cell_tag[i+1];
      end

      spq_cell #(
         .PRIO_W (PRIORITY_BITS),
         .TAG_W  (TAG_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (IDX < count_ff),
         .left_ge    (left_ge),
         .new_prio   (new_prio),
         .new_tag    (new_tag),
         .left_prio  (left_prio),
         .left_tag   (left_tag),
         .right_prio (right_prio),
         .right_tag  (right_tag),
         .ge         (cell_ge[i]),
         .prio       (cell_prio[i]),
         .tag        (cell_tag[i])
      );
   end

   // Response word and occupancy for the accepted request word.
   always_comb begin
      count_in    = count_ff;
      status_in   = spq_pkg::ST_ENQUEUED;
      out_tag_in  = '0;
      out_prio_in = '0;
      if (req_chan.command == spq_pkg::CMD_ENQUEUE) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            status_in = spq_pkg::ST_ENQUEUED;
            count_in  = count_ff + CNT_W'(1);
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            // The front slot is read before the chain shifts.
            status_in   = spq_pkg::ST_DEQUEUED;
            out_tag_in  = 64'(cell_tag[0]);
            out_prio_in = 8'(cell_prio[0]);
            count_in    = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff   <= status_in;
         out_tag_ff  <= out_tag_in;
         out_prio_ff <= out_prio_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.out_tag      = out_tag_ff;
   assign rsp_chan.out_priority = out_prio_ff;
   assign rsp_chan.occupancy    = 5'(count_ff);

endmodule

FILE: src/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority task queue checker
// Port-level checks on the response word, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_task_queue_defines.svh"

module spq_checker #(
   parameter int DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [63:0] rsp_out_tag,
   input logic [7:0]  rsp_out_priority,
   input logic [4:0]  rsp_occupancy
);

   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag) && $stable(rsp_occupancy), "response word changed while stalled")

   `SPQ_ASSERT_SAME(a_ready_when_free, !rsp_valid, req_ready, "intake closed with an empty response register")

   `SPQ_ASSERT_SAME(a_zero_fields, rsp_valid && (rsp_status != spq_pkg::ST_DEQUEUED), (rsp_out_tag == '0) && (rsp_out_priority == '0), "tag or priority set on a word that is not a removal")

   `SPQ_ASSERT_SAME(a_full_occupancy, rsp_valid && (rsp_status == spq_pkg::ST_FULL), rsp_occupancy == 5'(DEPTH), "full status with occupancy below depth")

   `SPQ_ASSERT_SAME(a_empty_occupancy, rsp_valid && (rsp_status == spq_pkg::ST_EMPTY), rsp_occupancy == '0, "empty status with nonzero occupancy")

endmodule

bind sorted_priority_task_queue spq_checker #(
   .DEPTH (DEPTH)
) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_out_tag      (rsp_chan.out_tag),
   .rsp_out_priority (rsp_chan.out_priority),
   .rsp_occupancy    (rsp_chan.occupancy)
);

FILE: tb/sorted_priority_task_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority task queue testbench
// Drives request words into the queue, predicts every response word from a
// private copy of the queue contents and compares each response field by field.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue_test;

   localparam int QUEUE_DEPTH  = 16;
   // Cycles in which no word moves on either channel before the run is abandoned.
   localparam int STALL_LIMIT  = 5000;
   // Length of the deliberate response-side stall that fills the pipeline.
   localparam int HOLD_CYCLES  = 300;
   // Extra cycles allowed after the last response for any stray word to show up.
   localparam int DRAIN_CYCLES = 8;

   // One response word as the queue should produce it.
   typedef struct packed {
      spq_pkg::status_type status;
      logic [63:0]         tag;
      logic [7:0]          prio;
      logic [4:0]          occupancy;
   } queue_result_type;

   // Keeps its own sorted copy of the queue. Each accepted request word updates
   // the copy and leaves one expected response word behind, which the next
   // accepted response word is compared against.
   class queue_scoreboard;
      logic [63:0]      held_tags[QUEUE_DEPTH];
      logic [7:0]       held_prios[QUEUE_DEPTH];
      int unsigned      held_count;
      queue_result_type awaited_results[$];
      int unsigned      errors;
      int unsigned      requests_noted;
      int unsigned      status_seen[4];

      function void note_request(logic cmd, logic [7:0] prio, logic [63:0] tag);
         queue_result_type want;
         int unsigned      slot;
         requests_noted++;
         want = '0;
         if (cmd == spq_pkg::CMD_ENQUEUE) begin
            if (held_count >= QUEUE_DEPTH) begin
               want.status = spq_pkg::ST_FULL;
            end else begin
               // The new task lands behind every entry of equal or higher
               // priority, which keeps equal priorities in arrival order.
               slot = 0;
               while (slot < held_count && held_prios[slot] >= prio)
                  slot++;
               for (int unsigned i = held_count; i > slot; i--) begin
                  held_tags[i]  = held_tags[i - 1];
                  held_prios[i] = held_prios[i - 1];
               end
               held_tags[slot]  = tag;
               held_prios[slot] = prio;
               held_count++;
               want.status = spq_pkg::ST_ENQUEUED;
            end
         end else begin
            if (held_count == 0) begin
               want.status = spq_pkg::ST_EMPTY;
            end else begin
               want.status = spq_pkg::ST_DEQUEUED;
               want.tag    = held_tags[0];
               want.prio   = held_prios[0];
               for (int unsigned i = 1; i < held_count; i++) begin
                  held_tags[i - 1]  = held_tags[i];
                  held_prios[i - 1] = held_prios[i];
               end
               held_count--;
            end
         end
         want.occupancy = held_count[4:0];
         awaited_results.push_back(want);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      endfunction

      function void check_response(logic [1:0] status, logic [63:0] tag,
                                   logic [7:0] prio, logic [4:0] occupancy);
         queue_result_type want;
         if (awaited_results.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, expected none, actual %0d %h %h %0d",
                     $time, status, tag, prio, occupancy);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("status", 64'(want.status), 64'(status));
         compare_field("out_tag", want.tag, tag);
         compare_field("out_priority", 64'(want.prio), 64'(prio));
         compare_field("occupancy", 64'(want.occupancy), 64'(occupancy));
         if (!$isunknown(status))
            status_seen[status]++;
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_task_queue #(
      .DEPTH         (QUEUE_DEPTH),
      .TAG_BYTES     (8),
      .PRIORITY_BITS (8)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   queue_scoreboard sb = new;

   // Pacing knobs, changed by the main sequence between phases.
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   // Set by the main sequence to ask the response side for a long stall.
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one request word and waits until the queue takes it. Signals are
   // read right after the rising edge, so they hold the values that the block
   // sampled at that edge. The valid line is left high; the next call either
   // keeps it high or drops it while it idles, so it is assigned once per step.
   task automatic send_word(logic cmd, logic [7:0] prio, logic [63:0] tag);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.priority_req <= prio;
      req_bus.task_tag     <= tag;
      do
         @(posedge clock);
      while (!req_bus.ready);
      sb.note_request(cmd, prio, tag);
   endtask

   // Random traffic in bursts of 32 words. Each burst leans toward enqueue or
   // dequeue so the queue keeps running into both the full and the empty case,
   // and picks a priority style: the full byte range, a narrow band that makes
   // ties common, or only the two extremes.
   task automatic run_random(int unsigned n_words);
      int unsigned enq_pct;
      int unsigned prio_mode;
      logic        cmd;
      logic [7:0]  prio;
      logic [63:0] tag;
      enq_pct   = 50;
      prio_mode = 0;
      for (int unsigned i = 0; i < n_words; i++) begin
         if (i % 32 == 0) begin
            case ($urandom_range(2))
               0:       enq_pct = 20;
               1:       enq_pct = 50;
               default: enq_pct = 85;
            endcase
            prio_mode = $urandom_range(2);
         end
         cmd = ($urandom_range(99) < enq_pct) ? spq_pkg::CMD_ENQUEUE : spq_pkg::CMD_DEQUEUE;
         case (prio_mode)
            0:       prio = 8'($urandom);
            1:       prio = 8'(8'd100 + $urandom_range(3));
            default: prio = $urandom_range(1) ? 8'hFF : 8'h00;
         endcase
         case ($urandom_range(15))
            0:       tag = '0;
            1:       tag = '1;
            default: tag = {$urandom, $urandom};
         endcase
         send_word(cmd, prio, tag);
      end
   endtask

   // Response side: checks every accepted response word, then chooses ready for
   // the next cycle. A requested hold keeps ready low for a counted stretch
   // while the sender keeps offering, so the block backs up and stalls intake.
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_bus.status, rsp_bus.out_tag, rsp_bus.out_priority,
                              rsp_bus.occupancy);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: a long run of cycles in which no word moves on either channel
   // means the block has hung.
   initial begin
      int unsigned quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no word moved for %0d cycles, %0d responses still expected",
               $time, STALL_LIMIT, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

   // Main sequence.
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.command      = spq_pkg::CMD_ENQUEUE;
      req_bus.priority_req = '0;
      req_bus.task_tag     = '0;
      hold_request         = 1'b0;
      send_idle_pct        = 15;
      rsp_idle_pct         = 87;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A dequeue on the empty queue comes first, with its
      // unused fields set to ones to show they are ignored.
      send_word(spq_pkg::CMD_DEQUEUE, 8'hFF, '1);
      // A tie with the only entry, a new front, a new rear, a tie at the rear
      // and a tie in the middle of the list.
      send_word(spq_pkg::CMD_ENQUEUE, 8'h80, 64'h0000_0000_0000_0001);
      send_word(spq_pkg::CMD_ENQUEUE, 8'h80, 64'h0000_0000_0000_0002);
      send_word(spq_pkg::CMD_ENQUEUE, 8'hFF, '1);
      send_word(spq_pkg::CMD_ENQUEUE, 8'h00, '0);
      send_word(spq_pkg::CMD_ENQUEUE, 8'h00, 64'h0000_0000_0000_0005);
      send_word(spq_pkg::CMD_ENQUEUE, 8'h80, 64'h0000_0000_0000_0006);
      // Fill the queue to the brim, then try one more, which must be dropped.
      for (int i = 0; i < QUEUE_DEPTH - 6; i++)
         send_word(spq_pkg::CMD_ENQUEUE, 8'(i * 25), {32'h5441_534B, 32'(i)});
      send_word(spq_pkg::CMD_ENQUEUE, 8'h7F, 64'hAAAA_5555_AAAA_5555);
      // The front entry leaves first, then the two highest priorities from the fill.
      repeat (3) send_word(spq_pkg::CMD_DEQUEUE, 8'h00, '0);

      // Random part in three pacing phases.
      run_random(340);
      send_idle_pct = 87;
      rsp_idle_pct  = 15;
      run_random(340);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = 1'b1;
      run_random(350);
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words over three pacing phases and one long response stall.",
               sb.requests_noted);
      $display("Responses: %0d enqueued, %0d dequeued, %0d empty, %0d dropped at full.",
               sb.status_seen[spq_pkg::ST_ENQUEUED], sb.status_seen[spq_pkg::ST_DEQUEUED],
               sb.status_seen[spq_pkg::ST_EMPTY], sb.status_seen[spq_pkg::ST_FULL]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
